FILE: rtl/pfa_pkg.sv
// Shared types and constants of the paged frame allocator.
// Holds the request and response word layouts, codes and fixed field widths.
// No dependencies.
package pfa_pkg;

    localparam int PID_W   = 8;
    localparam int SIZE_W  = 20;
    localparam int FSZ_W   = 16;
    localparam int FC_W    = 9;
    localparam int CNT_W   = 9;
    // Quotient width of the rounded-up page division: size + frame size - 1.
    localparam int QUO_W   = SIZE_W + 1;
    localparam int STEP_W  = $clog2(QUO_W + 1);

    localparam logic REG_FRAME_COUNT = 1'b0;
    localparam logic REG_FRAME_SIZE  = 1'b1;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_INSUFF    = 3'd1,
        STS_ALREADY   = 3'd2,
        STS_NOT_ALLOC = 3'd3,
        STS_BAD_SIZE  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLR,
        ST_OWN,
        ST_DIV,
        ST_CHECK,
        ST_CLAIM,
        ST_REMOVE,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [PID_W-1:0]    pid;
        logic [SIZE_W-1:0]   process_size_kb;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [CNT_W-1:0]    page_count;
    } t_rsp;

endpackage

FILE: rtl/paged_frame_allocator_top.sv
// Paged frame allocator: one request word at a time, one response word each.
// Allocate makes two scans of the owner RAM at one frame per cycle, with a
// one-bit-per-cycle divider between them; remove makes one scan and clear one clearing
// pass; requests rejected on entry go straight to the response. A new request is taken
// when the previous is done. Reset and any frame_count write start a clearing pass over
// the owner RAM, during which input is stalled. Depends on pfa_pkg and pfa_ram.
module paged_frame_allocator_top
    import pfa_pkg::*;
#(
    parameter int N_FRAMES = 256,
    parameter int MAX_PID  = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_req        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_rsp        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(N_FRAMES);
    localparam int CW = $clog2(N_FRAMES + 1);
    localparam int AW = (CW > FC_W) ? CW : FC_W;

    function automatic logic [AW-1:0] active_of(input logic [FC_W-1:0] fc);
        logic [AW-1:0] fcw;
        fcw = AW'(fc);
        return (fcw > AW'(N_FRAMES)) ? AW'(N_FRAMES) : fcw;
    endfunction

    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic                r_rd_vld, n_rd_vld;
    logic [IW-1:0]       r_chk_addr, n_chk_addr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_free, n_free;
    logic [QUO_W-1:0]    r_quo, n_quo;
    logic [FSZ_W-1:0]    r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [PID_W-1:0]    r_pid, n_pid;
    t_status             r_status, n_status;
    logic                r_clr_rsp, n_clr_rsp;
    logic [FC_W-1:0]     r_frame_count, n_frame_count;
    logic [FSZ_W-1:0]    r_frame_size, n_frame_size;
    logic                r_out_vld, n_out_vld;
    t_rsp                r_out, n_out;

    logic [AW-1:0]       active;
    logic                in_acc, cfg_wr, pid_ok;
    logic                scan_issue, scan_end;
    logic [FSZ_W:0]      rem_sh, rem_sub;
    logic                div_ge;
    logic                ram_we, ram_re;
    logic [IW-1:0]       ram_waddr;
    logic [PID_W-1:0]    ram_wdata, ram_rdata;

    pfa_ram #(
        .WIDTH(PID_W),
        .DEPTH(N_FRAMES)
    ) u_owner_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_addr[IW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign active     = active_of(r_frame_count);
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cfg_wr     = psel && penable && pwrite;
    assign pid_ok     = (i_in_data.pid != '0) && (32'(i_in_data.pid) <= 32'(MAX_PID));
    assign scan_issue = (r_addr < active);
    assign scan_end   = !scan_issue && !r_rd_vld;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign rem_sh  = {r_rem, r_quo[QUO_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_frame_size});
    assign rem_sub = rem_sh - {1'b0, r_frame_size};

    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_FRAME_SIZE) ? {16'b0, r_frame_size}
                                                      : {23'b0, r_frame_count};
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        n_rd_vld      = r_rd_vld;
        n_chk_addr    = r_chk_addr;
        n_count       = r_count;
        n_free        = r_free;
        n_quo         = r_quo;
        n_rem         = r_rem;
        n_step        = r_step;
        n_pid         = r_pid;
        n_status      = r_status;
        n_clr_rsp     = r_clr_rsp;
        n_frame_count = r_frame_count;
        n_frame_size  = r_frame_size;
        n_out         = r_out;
        n_out_vld     = r_out_vld && i_out_stall;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = r_chk_addr;
        ram_wdata     = r_pid;

        // Shared scan engine: issue one read per cycle, handle its data the next cycle.
        if (r_state == ST_OWN || r_state == ST_CLAIM || r_state == ST_REMOVE) begin
            if (scan_issue) begin
                ram_re     = 1'b1;
                n_addr     = r_addr + AW'(1);
                n_rd_vld   = 1'b1;
                n_chk_addr = r_addr[IW-1:0];
            end else begin
                n_rd_vld   = 1'b0;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_pid    = i_in_data.pid;
                    n_count  = '0;
                    n_status = STS_OK;
                    n_addr   = '0;
                    n_rd_vld = 1'b0;
                    n_quo    = QUO_W'(i_in_data.process_size_kb) + QUO_W'(r_frame_size)
                               - QUO_W'(1);
                    unique case (i_in_data.action)
                        ACT_ALLOC: begin
                            if (!pid_ok) begin
                                n_status = STS_NOT_ALLOC;
                                n_state  = ST_DONE;
                            end else if (i_in_data.process_size_kb == '0 ||
                                         r_frame_size == '0) begin
                                n_status = STS_BAD_SIZE;
                                n_state  = ST_DONE;
                            end else begin
                                n_state  = ST_OWN;
                            end
                        end
                        ACT_REMOVE: begin
                            if (!pid_ok) begin
                                n_status = STS_NOT_ALLOC;
                                n_state  = ST_DONE;
                            end else begin
                                n_state  = ST_REMOVE;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count   = CNT_W'(active) - r_free;
                            n_free    = CNT_W'(active);
                            n_clr_rsp = 1'b1;
                            n_state   = ST_CLR;
                        end
                        ACT_NOP: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[IW-1:0];
                ram_wdata = '0;
                n_addr    = r_addr + AW'(1);
                if (r_addr == AW'(N_FRAMES - 1)) begin
                    n_state = r_clr_rsp ? ST_DONE : ST_IDLE;
                end
            end
            ST_OWN: begin
                if (r_rd_vld && ram_rdata == r_pid) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (scan_end) begin
                    if (r_count != '0) begin
                        n_status = STS_ALREADY;
                        n_count  = '0;
                        n_state  = ST_DONE;
                    end else begin
                        n_rem   = '0;
                        n_step  = STEP_W'(QUO_W);
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_rem  = div_ge ? rem_sub[FSZ_W-1:0] : rem_sh[FSZ_W-1:0];
                n_quo  = {r_quo[QUO_W-2:0], div_ge};
                n_step = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_quo > QUO_W'(r_free)) begin
                    n_status = STS_INSUFF;
                    n_count  = '0;
                    n_state  = ST_DONE;
                end else begin
                    n_count  = '0;
                    n_addr   = '0;
                    n_rd_vld = 1'b0;
                    n_state  = ST_CLAIM;
                end
            end
            ST_CLAIM: begin
                // Reads issued past the last needed frame are simply not used.
                if (r_rd_vld && ram_rdata == '0 && QUO_W'(r_count) < r_quo) begin
                    ram_we  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
                if (scan_end) begin
                    n_free  = r_free - r_count;
                    n_state = ST_DONE;
                end
            end
            ST_REMOVE: begin
                if (r_rd_vld && ram_rdata == r_pid) begin
                    ram_we    = 1'b1;
                    ram_wdata = '0;
                    n_count   = r_count + CNT_W'(1);
                end
                if (scan_end) begin
                    if (r_count == '0) begin
                        n_status = STS_NOT_ALLOC;
                    end else begin
                        n_free = r_free + r_count;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out.status     = r_status;
                    n_out.page_count = r_count;
                    n_out_vld        = 1'b1;
                    n_clr_rsp        = 1'b0;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A new frame count frees every frame, so the owner RAM is swept again.
        if (cfg_wr) begin
            if (paddr[2] == REG_FRAME_COUNT) begin
                n_frame_count = pwdata[FC_W-1:0];
                n_free        = CNT_W'(active_of(pwdata[FC_W-1:0]));
                n_addr        = '0;
                n_rd_vld      = 1'b0;
                n_clr_rsp     = 1'b0;
                n_state       = ST_CLR;
            end else begin
                n_frame_size  = pwdata[FSZ_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLR;
            r_addr        <= '0;
            r_rd_vld      <= 1'b0;
            r_clr_rsp     <= 1'b0;
            r_frame_count <= FC_W'(256);
            r_frame_size  <= FSZ_W'(4);
            r_free        <= CNT_W'(active_of(FC_W'(256)));
            r_out_vld     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_addr        <= n_addr;
            r_rd_vld      <= n_rd_vld;
            r_clr_rsp     <= n_clr_rsp;
            r_frame_count <= n_frame_count;
            r_frame_size  <= n_frame_size;
            r_free        <= n_free;
            r_out_vld     <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr <= n_chk_addr;
        r_count    <= n_count;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_pid      <= n_pid;
        r_status   <= n_status;
        r_out      <= n_out;
    end

`ifndef SYNTHESIS
    a_free_le_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        AW'(r_free) <= active)
        else $error("free frame count exceeds active frames");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("accepted request did not start work");

    a_claim_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLAIM) |-> (QUO_W'(r_count) <= r_quo))
        else $error("claimed more frames than requested pages");

    a_idle_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_rd_vld)
        else $error("scan data pending while idle");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_step != '0))
        else $error("divider ran past its last step");
`endif

endmodule

FILE: rtl/pfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/pfa_checker.sv
`timescale 1ns / 100ps
// Response checker for the paged frame allocator: it follows the request, response and
// register ports, keeps its own copy of the frame ownership tags and compares each response
// word in order. Depends on pfa_pkg.
module pfa_checker
    import pfa_pkg::*;
#(
    parameter int N_FRAMES = 256,
    parameter int MAX_PID  = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_req        i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_rsp        i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    logic [PID_W-1:0] frame_tag [N_FRAMES];
    int unsigned      free_left;
    logic [FC_W-1:0]  cfg_frames;
    logic [FSZ_W-1:0] cfg_frame_kb;
    t_rsp             owed_responses [$];
    int               mismatches = 0;
    int               responses_seen = 0;

    assign o_errors  = mismatches;
    assign o_checked = responses_seen;

    function automatic int unsigned active_limit();
        return (cfg_frames > N_FRAMES) ? N_FRAMES : cfg_frames;
    endfunction

    function automatic void release_all();
        for (int f = 0; f < N_FRAMES; f++) frame_tag[f] = '0;
        free_left = active_limit();
    endfunction

    // Applies one request to the ownership tags and returns the response it must produce.
    function automatic t_rsp apply_request(t_req r);
        t_rsp        res;
        int unsigned lim;
        int unsigned held;
        int unsigned moved;
        logic [63:0] pages;
        logic        pid_ok;
        res.status = STS_OK;
        moved = 0;
        held = 0;
        lim = active_limit();
        pid_ok = (r.pid != 0) && (r.pid <= MAX_PID);
        case (r.action)
            ACT_ALLOC: begin
                for (int f = 0; f < lim; f++) if (frame_tag[f] == r.pid) held++;
                if (!pid_ok) begin
                    res.status = STS_NOT_ALLOC;
                end else if (r.process_size_kb == 0 || cfg_frame_kb == 0) begin
                    res.status = STS_BAD_SIZE;
                end else if (held != 0) begin
                    res.status = STS_ALREADY;
                end else begin
                    pages = (64'(r.process_size_kb) + 64'(cfg_frame_kb) - 64'd1)
                            / 64'(cfg_frame_kb);
                    if (pages > 64'(free_left)) begin
                        res.status = STS_INSUFF;
                    end else begin
                        // Lowest-numbered free frames go first.
                        for (int f = 0; f < lim && 64'(moved) < pages; f++) begin
                            if (frame_tag[f] == 0) begin
                                frame_tag[f] = r.pid;
                                moved++;
                            end
                        end
                        free_left -= moved;
                    end
                end
            end
            ACT_REMOVE: begin
                if (!pid_ok) begin
                    res.status = STS_NOT_ALLOC;
                end else begin
                    for (int f = 0; f < lim; f++) begin
                        if (frame_tag[f] == r.pid) begin
                            frame_tag[f] = '0;
                            moved++;
                        end
                    end
                    if (moved == 0) res.status = STS_NOT_ALLOC;
                    free_left += moved;
                end
            end
            ACT_CLEAR: begin
                moved = lim - free_left;
                release_all();
            end
            default: ;
        endcase
        res.page_count = CNT_W'(moved);
        return res;
    endfunction

    function automatic void flag_failure(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t ERROR %s", $time, msg);
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            cfg_frames = FC_W'(256);
            cfg_frame_kb = FSZ_W'(4);
            release_all();
            owed_responses.delete();
        end else begin
            // A response leaving now belongs to an earlier request, so retire it first.
            if (i_out_valid && !i_out_stall) begin
                responses_seen++;
                if (owed_responses.size() == 0) begin
                    flag_failure($sformatf("word with no request waiting: status %0d count %0d",
                                           i_out_data.status, i_out_data.page_count));
                end else begin
                    want = owed_responses.pop_front();
                    if (i_out_data.status !== want.status ||
                        i_out_data.page_count !== want.page_count)
                        flag_failure($sformatf(
                            "word %0d: status %0d count %0d, expected status %0d count %0d",
                            responses_seen, i_out_data.status, i_out_data.page_count,
                            want.status, want.page_count));
                end
            end
            if (i_in_valid && !i_in_stall)
                owed_responses.insert(owed_responses.size(), apply_request(i_in_data));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_FRAME_COUNT, 2'b00}) begin
                    cfg_frames = i_pwdata[FC_W-1:0];
                    release_all();
                end else if (i_paddr == {REG_FRAME_SIZE, 2'b00}) begin
                    cfg_frame_kb = i_pwdata[FSZ_W-1:0];
                end
            end
        end
        o_pending <= owed_responses.size();
    end

endmodule

FILE: tb/paged_frame_allocator_top_tb.sv
`timescale 1ns / 100ps
// Top of the paged frame allocator testbench: clock, reset, request and register stimulus,
// watchdog and verdict. Depends on pfa_pkg, paged_frame_allocator_top and pfa_checker.
module paged_frame_allocator_top_tb;
    import pfa_pkg::*;

    localparam int N_FRAMES        = 256;
    localparam int MAX_PID         = 255;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 72;
    localparam int HOLD_CYCLES     = 1500;
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int SETTLE_CYCLES   = 600;

    localparam logic [2:0] ADDR_FRAME_COUNT = {REG_FRAME_COUNT, 2'b00};
    localparam logic [2:0] ADDR_FRAME_SIZE  = {REG_FRAME_SIZE, 2'b00};

    // Memory settings per phase; the upper bits of some words are junk the block must drop.
    localparam logic [31:0] PH_FRAMES [PHASES] = '{
        32'd256, 32'd16, 32'd1, 32'd0, 32'd511, 32'hFFFF_FE40, 32'd200, 32'd256, 32'd8, 32'd256};
    localparam logic [31:0] PH_KB [PHASES] = '{
        32'd4, 32'd1, 32'd65535, 32'd4, 32'd4096, 32'h5A5A_0003, 32'd0, 32'd1, 32'd2, 32'd16};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_req        i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_rsp        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          chk_errors;
    int          chk_pending;
    int          chk_checked;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_asked = 0;
    int          quiet_cycles = 0;
    int          sent_by_action [4] = '{0, 0, 0, 0};
    int unsigned cur_frames = 256;
    int unsigned cur_kb = 4;

    paged_frame_allocator_top #(
        .N_FRAMES (N_FRAMES),
        .MAX_PID  (MAX_PID)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pfa_checker #(
        .N_FRAMES (N_FRAMES),
        .MAX_PID  (MAX_PID)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_checked   (chk_checked)
    );

    always #5 i_clk = ~i_clk;

    // Ends the run when nothing moves on any port for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Response side: random stalls, plus long hold-offs on request from the stimulus.
    initial begin
        int hold_left;
        int hold_served;
        hold_left = 0;
        hold_served = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && hold_served != hold_asked) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic t_req req_of(t_action act, int pid, int size_kb);
        t_req r;
        r.action = act;
        r.pid = PID_W'(pid);
        r.process_size_kb = SIZE_W'(size_kb);
        return r;
    endfunction

    // Mostly well-formed traffic from a small set of PIDs so that frames fill up and
    // PIDs collide; the rest is raw random words.
    function automatic t_req random_request(int unsigned lim, int unsigned kb);
        t_req                     r;
        logic [$bits(t_req)-1:0]  raw;
        logic [31:0]              rnd;
        int unsigned              pick;
        int unsigned              pages;
        int unsigned              kb_eff;
        logic [63:0]              total_kb;
        pick = $urandom_range(99);
        kb_eff = (kb == 0) ? 4 : kb;
        r = req_of(ACT_REMOVE, $urandom_range(8, 1), 0);
        if (pick < 50) begin
            r.action = ACT_ALLOC;
            pages = $urandom_range((lim > 3) ? lim / 3 : 1, 1);
            total_kb = 64'(pages) * 64'(kb_eff) - 64'($urandom_range(kb_eff - 1, 0));
            r.process_size_kb = (total_kb > 64'hF_FFFF) ? 20'hF_FFFF : total_kb[SIZE_W-1:0];
        end else if (pick < 80) begin
            r.action = ACT_REMOVE;
        end else if (pick < 85) begin
            r.action = ACT_CLEAR;
        end else if (pick < 88) begin
            r.action = ACT_NOP;
        end else begin
            rnd = $urandom;
            raw = rnd[$bits(t_req)-1:0];
            r = raw;
        end
        return r;
    endfunction

    task automatic send_req(input t_req r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        do @(posedge i_clk); while (o_in_stall);
        sent_by_action[int'(r.action)]++;
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Stops offering words and waits until every response has come back.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int unsigned lim;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the reset setting: 256 frames of 4 KB.
        send_req(req_of(ACT_ALLOC, 1, 1));
        send_req(req_of(ACT_ALLOC, 1, 4));
        send_req(req_of(ACT_ALLOC, 2, 5));
        send_req(req_of(ACT_ALLOC, 3, 0));
        send_req(req_of(ACT_ALLOC, 0, 8));
        send_req(req_of(ACT_ALLOC, 255, 20'hF_FFFF));
        send_req(req_of(ACT_ALLOC, 255, 1012));
        send_req(req_of(ACT_ALLOC, 4, 1));
        send_req(req_of(ACT_REMOVE, 2, 0));
        send_req(req_of(ACT_ALLOC, 4, 8));
        send_req(req_of(ACT_REMOVE, 0, 0));
        send_req(req_of(ACT_REMOVE, 77, 0));
        send_req(req_of(ACT_NOP, 8'hAA, 20'h5_5555));
        send_req(req_of(ACT_CLEAR, 0, 0));
        send_req(req_of(ACT_CLEAR, 9, 20'hA_AAAA));
        send_req(req_of(ACT_REMOVE, 1, 0));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            reg_write(ADDR_FRAME_COUNT, PH_FRAMES[ph]);
            reg_write(ADDR_FRAME_SIZE, PH_KB[ph]);
            cur_frames = PH_FRAMES[ph][FC_W-1:0];
            cur_kb = PH_KB[ph][FSZ_W-1:0];
            lim = (cur_frames > N_FRAMES) ? N_FRAMES : cur_frames;
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 8; stall_pct = 8; end
            endcase
            // Back-pressure long enough for the block to fill and stall its input.
            if (ph == 1 || ph == 6) hold_asked++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_req(random_request(lim, cur_kb));
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Sent %0d allocate, %0d remove, %0d clear and %0d no-op words over %0d settings",
                 sent_by_action[0], sent_by_action[1], sent_by_action[2], sent_by_action[3],
                 PHASES + 1);
        $display("Compared %0d response words, %0d mismatched", chk_checked, chk_errors);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
